FILE: rtl/core/dvcp_pkg.sv
// Shared types, constants and helpers for the dominant vibrant color picker.
// Depends on nothing; the core modules and the testbench refer to it by scoped names.
package dvcp_pkg;

   localparam int unsigned ChanW    = 8;
   localparam int unsigned SatW     = 16;
   localparam int unsigned WeightW  = 9;
   localparam int unsigned ProdW    = SatW + WeightW - 1;
   localparam int unsigned ScoreW   = 17;
   localparam int unsigned ColorW   = 4 * ChanW;
   localparam int unsigned DivCntW  = $clog2(SatW);
   localparam int unsigned QDepth   = 4;
   localparam int unsigned QPtrW    = $clog2(QDepth);
   localparam int unsigned QCntW    = $clog2(QDepth + 1);
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 16;

   localparam logic [WeightW-1:0] WeightOne = WeightW'(1) << (WeightW - 1);
   localparam logic [DivCntW-1:0] DivLast   = DivCntW'(SatW - 1);

   // Register indexes of the configuration port.
   localparam logic [CsrIdxW-1:0] CsrMinAlpha = 3'd0;
   localparam logic [CsrIdxW-1:0] CsrMinSat   = 3'd1;
   localparam logic [CsrIdxW-1:0] CsrMinValue = 3'd2;
   localparam logic [CsrIdxW-1:0] CsrMaxValue = 3'd3;
   localparam logic [CsrIdxW-1:0] CsrSatWgt   = 3'd4;
   localparam logic [CsrIdxW-1:0] CsrValWgt   = 3'd5;

   typedef struct packed {
      logic [ChanW-1:0]   min_alpha;
      logic [SatW-1:0]    min_sat;
      logic [ChanW-1:0]   min_value;
      logic [ChanW-1:0]   max_value;
      logic [WeightW-1:0] sat_weight;
      logic [WeightW-1:0] value_weight;
   } cfg_type;

   // One classified pixel as it travels from the front to the back.
   typedef struct packed {
      logic [ChanW-1:0] red;
      logic [ChanW-1:0] green;
      logic [ChanW-1:0] blue;
      logic [ChanW-1:0] alpha;
      logic [ChanW-1:0] hi;
      logic [ChanW-1:0] diff;
      logic             active;
      logic             last;
   } pix_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      BkIdle,
      BkDiv,
      BkMul,
      BkUpd,
      BkSend
   } back_state_type;

   // Weights above one count as one.
   function automatic logic [WeightW-1:0] clamp_weight(input logic [WeightW-1:0] w);
      return w[WeightW-1] ? WeightOne : w;
   endfunction

endpackage

FILE: rtl/core/dvcp_req_if.sv
// Pixel channel: valid/ready handshake with one RGBA pixel and a last mark.
// Depends on nothing.
interface dvcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [7:0] alpha;
   logic       last;

   modport source(output valid, red, green, blue, alpha, last, input ready);
   modport sink(input valid, red, green, blue, alpha, last, output ready);
endinterface

FILE: rtl/core/dvcp_rsp_if.sv
// Result channel: valid/ready handshake with the found flag and the chosen color.
// Depends on nothing.
interface dvcp_rsp_if;
   logic       valid;
   logic       ready;
   logic       found;
   logic [7:0] out_red;
   logic [7:0] out_green;
   logic [7:0] out_blue;
   logic [7:0] out_alpha;

   modport source(output valid, found, out_red, out_green, out_blue, out_alpha, input ready);
   modport sink(input valid, found, out_red, out_green, out_blue, out_alpha, output ready);
endinterface

FILE: rtl/core/dominant_vibrant_color_picker_unit.sv
// Top level of the dominant vibrant color picker: configuration registers, front,
// queue and back. Depends on dvcp_pkg, dvcp_req_if, dvcp_rsp_if and the core modules.
//
//   channel    direction  contents
//   req_chan   in         red, green, blue, alpha, last (valid/ready)
//   rsp_chan   out        found, out_red, out_green, out_blue, out_alpha (valid/ready)
//   csr_*      in         write enable, register index, 16-bit data
//
// The front takes a pixel in any cycle in which the four-entry queue has room.
// The back handles a pixel that fails alpha or the value window in its idle state;
// one that passes runs through the one-bit-a-cycle saturation divider, then multiply
// and compare; a last pixel also takes a send state that loads the result register.
// Reset is synchronous and clears the queue, the candidate and the result valid.
// A waiting result stalls the back only at its next send; the front keeps filling.
module dominant_vibrant_color_picker_unit (
   input  logic                              clock,
   input  logic                              reset,
   dvcp_req_if.sink                          req_chan,
   dvcp_rsp_if.source                        rsp_chan,
   input  logic                              csr_wr_en,
   input  logic [dvcp_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [dvcp_pkg::CsrDataW-1:0]     csr_wdata
);

   dvcp_pkg::cfg_type        cfg_ff, cfg_in;
   dvcp_pkg::pix_type        push_pix;
   dvcp_pkg::pix_type        head_pix;
   dvcp_pkg::q_status_type   q_status;
   logic                     push;
   logic                     pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            dvcp_pkg::CsrMinAlpha: cfg_in.min_alpha    = csr_wdata[7:0];
            dvcp_pkg::CsrMinSat:   cfg_in.min_sat      = csr_wdata;
            dvcp_pkg::CsrMinValue: cfg_in.min_value    = csr_wdata[7:0];
            dvcp_pkg::CsrMaxValue: cfg_in.max_value    = csr_wdata[7:0];
            dvcp_pkg::CsrSatWgt:   cfg_in.sat_weight   = csr_wdata[8:0];
            dvcp_pkg::CsrValWgt:   cfg_in.value_weight = csr_wdata[8:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_alpha    <= 8'd200;
         cfg_ff.min_sat      <= 16'd22938;
         cfg_ff.min_value    <= 8'd77;
         cfg_ff.max_value    <= 8'd244;
         cfg_ff.sat_weight   <= 9'd179;
         cfg_ff.value_weight <= 9'd77;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   dvcp_front u_front (
      .req      (req_chan),
      .cfg      (cfg_ff),
      .q_status (q_status),
      .push     (push),
      .pix      (push_pix)
   );

   dvcp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_pix (push_pix),
      .pop      (pop),
      .head_pix (head_pix),
      .q_status (q_status)
   );

   dvcp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .head_pix (head_pix),
      .q_status (q_status),
      .pop      (pop),
      .rsp      (rsp_chan)
   );

endmodule

FILE: rtl/core/dvcp_front.sv
// Front end: accepts pixels and classifies them (alpha test, largest and smallest
// channel, value window). Depends on dvcp_pkg and dvcp_req_if.
module dvcp_front (
   dvcp_req_if.sink                 req,
   input  dvcp_pkg::cfg_type        cfg,
   input  dvcp_pkg::q_status_type   q_status,
   output logic                     push,
   output dvcp_pkg::pix_type        pix
);

   logic [dvcp_pkg::ChanW-1:0] hi;
   logic [dvcp_pkg::ChanW-1:0] lo;

   always_comb begin
      hi = req.red;
      lo = req.red;
      if (req.green > hi) hi = req.green;
      if (req.blue > hi) hi = req.blue;
      if (req.green < lo) lo = req.green;
      if (req.blue < lo) lo = req.blue;
   end

   assign req.ready = !q_status.full;
   assign push      = req.valid && !q_status.full;

   always_comb begin
      pix.red    = req.red;
      pix.green  = req.green;
      pix.blue   = req.blue;
      pix.alpha  = req.alpha;
      pix.hi     = hi;
      pix.diff   = hi - lo;
      // Only a pixel that passes alpha and the value window needs the divider.
      pix.active = (req.alpha >= cfg.min_alpha) && (hi >= cfg.min_value)
                   && (hi <= cfg.max_value);
      pix.last   = req.last;
   end

endmodule

FILE: rtl/core/dvcp_queue.sv
// Short pixel queue between the front and the back, held in flip-flops.
// Depends on dvcp_pkg.
module dvcp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  dvcp_pkg::pix_type        push_pix,
   input  logic                     pop,
   output dvcp_pkg::pix_type        head_pix,
   output dvcp_pkg::q_status_type   q_status
);

   dvcp_pkg::pix_type                 mem_ff [dvcp_pkg::QDepth];
   logic [dvcp_pkg::QPtrW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [dvcp_pkg::QPtrW-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [dvcp_pkg::QCntW-1:0]        cnt_ff, cnt_in;

   assign q_status.full  = (cnt_ff == dvcp_pkg::QCntW'(dvcp_pkg::QDepth));
   assign q_status.empty = (cnt_ff == '0);
   assign head_pix       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_pix;
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full) else $error("queue written while full");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty) else $error("queue read while empty");

endmodule

FILE: rtl/core/dvcp_back.sv
// Back end: saturation divider, score multipliers, best-pixel tracking and the
// result register. Depends on dvcp_pkg and dvcp_rsp_if.
module dvcp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  dvcp_pkg::cfg_type        cfg,
   input  dvcp_pkg::pix_type        head_pix,
   input  dvcp_pkg::q_status_type   q_status,
   output logic                     pop,
   dvcp_rsp_if.source               rsp
);

   dvcp_pkg::back_state_type          state_ff, state_in;
   logic [dvcp_pkg::ColorW-1:0]       color_ff, color_in;
   logic [dvcp_pkg::ChanW-1:0]        hi_ff, hi_in;
   logic [dvcp_pkg::ChanW-1:0]        rem_ff, rem_in;
   logic [dvcp_pkg::SatW-1:0]         quo_ff, quo_in;
   logic [dvcp_pkg::DivCntW-1:0]      cnt_ff, cnt_in;
   logic                              last_ff, last_in;
   logic [dvcp_pkg::ProdW-1:0]        prod_s_ff, prod_s_in;
   logic [dvcp_pkg::ProdW-1:0]        prod_v_ff, prod_v_in;
   logic                              vib_ff, vib_in;
   logic [dvcp_pkg::ScoreW-1:0]       best_score_ff, best_score_in;
   logic [dvcp_pkg::ColorW-1:0]       best_color_ff, best_color_in;
   logic                              have_ff, have_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              found_ff, found_in;
   logic [dvcp_pkg::ColorW-1:0]       out_color_ff, out_color_in;

   logic                              load;
   logic                              div_step;
   logic                              mul_en;
   logic                              upd_en;
   logic                              send;
   logic                              out_free;
   logic [dvcp_pkg::ChanW:0]          rem_dbl;
   logic                              quo_bit;
   logic [dvcp_pkg::ProdW:0]          score_sum;
   logic [dvcp_pkg::ScoreW-1:0]       score;

   assign out_free = !rsp_valid_ff || rsp.ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dvcp_pkg::BkIdle: begin
            if (!q_status.empty) begin
               if (head_pix.active) state_in = dvcp_pkg::BkDiv;
               else if (head_pix.last) state_in = dvcp_pkg::BkSend;
            end
         end
         dvcp_pkg::BkDiv: begin
            if (cnt_ff == dvcp_pkg::DivLast) state_in = dvcp_pkg::BkMul;
         end
         dvcp_pkg::BkMul: state_in = dvcp_pkg::BkUpd;
         dvcp_pkg::BkUpd: state_in = last_ff ? dvcp_pkg::BkSend : dvcp_pkg::BkIdle;
         dvcp_pkg::BkSend: begin
            if (out_free) state_in = dvcp_pkg::BkIdle;
         end
         default: state_in = dvcp_pkg::BkIdle;
      endcase
   end

   // State outputs.
   always_comb begin
      load     = 1'b0;
      div_step = 1'b0;
      mul_en   = 1'b0;
      upd_en   = 1'b0;
      send     = 1'b0;
      unique case (state_ff)
         dvcp_pkg::BkIdle: load = !q_status.empty;
         dvcp_pkg::BkDiv: div_step = 1'b1;
         dvcp_pkg::BkMul: mul_en = 1'b1;
         dvcp_pkg::BkUpd: upd_en = 1'b1;
         dvcp_pkg::BkSend: send = out_free;
         default: ;
      endcase
   end

   assign pop = load;

   // One quotient bit a cycle. A zero divisor leaves the quotient at zero, and a
   // difference equal to the divisor yields all ones, which is the saturation cap.
   assign rem_dbl = {rem_ff, 1'b0};
   assign quo_bit = (hi_ff != '0) && (rem_dbl >= {1'b0, hi_ff});

   assign score_sum = {1'b0, prod_s_ff} + {1'b0, prod_v_ff};
   assign score     = score_sum[dvcp_pkg::ProdW -: dvcp_pkg::ScoreW];

   always_comb begin
      color_in      = color_ff;
      hi_in         = hi_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      last_in       = last_ff;
      prod_s_in     = prod_s_ff;
      prod_v_in     = prod_v_ff;
      vib_in        = vib_ff;
      best_score_in = best_score_ff;
      best_color_in = best_color_ff;
      have_in       = have_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      found_in      = found_ff;
      out_color_in  = out_color_ff;

      if (load) begin
         color_in = {head_pix.red, head_pix.green, head_pix.blue, head_pix.alpha};
         hi_in    = head_pix.hi;
         rem_in   = head_pix.diff;
         quo_in   = '0;
         cnt_in   = '0;
         last_in  = head_pix.last;
      end
      if (div_step) begin
         rem_in = quo_bit ? dvcp_pkg::ChanW'(rem_dbl - {1'b0, hi_ff})
                          : rem_dbl[dvcp_pkg::ChanW-1:0];
         quo_in = {quo_ff[dvcp_pkg::SatW-2:0], quo_bit};
         cnt_in = cnt_ff + 1'b1;
      end
      if (mul_en) begin
         vib_in    = (quo_ff >= cfg.min_sat);
         prod_s_in = dvcp_pkg::ProdW'(quo_ff)
                     * dvcp_pkg::ProdW'(dvcp_pkg::clamp_weight(cfg.sat_weight));
         // hi * 257 is hi repeated in both bytes.
         prod_v_in = dvcp_pkg::ProdW'({hi_ff, hi_ff})
                     * dvcp_pkg::ProdW'(dvcp_pkg::clamp_weight(cfg.value_weight));
      end
      if (upd_en && vib_ff && (!have_ff || score > best_score_ff)) begin
         have_in       = 1'b1;
         best_score_in = score;
         best_color_in = color_ff;
      end
      if (send) begin
         rsp_valid_in = 1'b1;
         found_in     = have_ff;
         out_color_in = have_ff ? best_color_ff : '0;
         have_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dvcp_pkg::BkIdle;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      color_ff      <= color_in;
      hi_ff         <= hi_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      cnt_ff        <= cnt_in;
      last_ff       <= last_in;
      prod_s_ff     <= prod_s_in;
      prod_v_ff     <= prod_v_in;
      vib_ff        <= vib_in;
      best_score_ff <= best_score_in;
      best_color_ff <= best_color_in;
      found_ff      <= found_in;
      out_color_ff  <= out_color_in;
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.found     = found_ff;
   assign rsp.out_red   = out_color_ff[31:24];
   assign rsp.out_green = out_color_ff[23:16];
   assign rsp.out_blue  = out_color_ff[15:8];
   assign rsp.out_alpha = out_color_ff[7:0];

   a_mul_after_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == dvcp_pkg::BkMul |-> $past(state_ff) == dvcp_pkg::BkDiv
                                      && $past(cnt_ff) == dvcp_pkg::DivLast)
      else $error("multiply stage entered before the divider finished");
   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.found |-> rsp.out_red == '0 && rsp.out_green == '0
                                  && rsp.out_blue == '0 && rsp.out_alpha == '0)
      else $error("result without a vibrant pixel carries a color");
   a_clear_after_send: assert property (@(posedge clock) disable iff (reset)
      send |=> !have_ff) else $error("candidate not cleared after a result");

endmodule

FILE: verif/dominant_vibrant_color_picker_unit_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for dominant_vibrant_color_picker_unit: streams images of RGBA
// pixels, predicts the kept vibrant color per image and checks every result field.
// Depends on dvcp_pkg, dvcp_req_if, dvcp_rsp_if and the block itself.
module dominant_vibrant_color_picker_unit_test;

   localparam int SettleCycles  = 120;
   localparam int WatchdogLimit = 5000;
   localparam int HoldOffCycles = 400;
   localparam int unsigned SatCap    = 65535;
   localparam int unsigned WeightMax = 256;
   localparam int unsigned ValueScale = 257;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic       found;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } pick_type;

   // Tracks the best vibrant pixel of the current image and the picks still owed.
   class vibrant_pick_board;
      dvcp_pkg::cfg_type settings;
      logic [16:0]       best_score;
      logic [31:0]       best_color;
      bit                have_pick;
      pick_type          expected_picks[$];
      int                errors;

      function new();
         settings.min_alpha    = 8'd200;
         settings.min_sat      = 16'd22938;
         settings.min_value    = 8'd77;
         settings.max_value    = 8'd244;
         settings.sat_weight   = 9'd179;
         settings.value_weight = 9'd77;
         best_score = '0;
         best_color = '0;
         have_pick  = 1'b0;
         errors     = 0;
      endfunction

      function void note_pixel(input logic [7:0] red, green, blue, alpha, input logic last);
         int unsigned hi, lo, sat, score, sw, vw;
         pick_type    pick;
         if (alpha >= settings.min_alpha) begin
            hi = red;
            lo = red;
            if (green > hi) hi = green;
            if (blue > hi) hi = blue;
            if (green < lo) lo = green;
            if (blue < lo) lo = blue;
            sat = 0;
            if (hi != 0) begin
               sat = ((hi - lo) << 16) / hi;
               if (sat > SatCap) sat = SatCap;
            end
            if (sat >= settings.min_sat && hi >= settings.min_value
                && hi <= settings.max_value) begin
               sw = (settings.sat_weight > WeightMax) ? WeightMax : settings.sat_weight;
               vw = (settings.value_weight > WeightMax) ? WeightMax : settings.value_weight;
               score = (sat * sw + hi * ValueScale * vw) >> 8;
               // Only a strictly better score replaces the pixel already kept.
               if (!have_pick || score > best_score) begin
                  have_pick  = 1'b1;
                  best_score = score[16:0];
                  best_color = {red, green, blue, alpha};
               end
            end
         end
         if (last) begin
            pick.found = have_pick;
            pick.red   = best_color[31:24];
            pick.green = best_color[23:16];
            pick.blue  = best_color[15:8];
            pick.alpha = best_color[7:0];
            expected_picks.push_back(pick);
            best_score = '0;
            best_color = '0;
            have_pick  = 1'b0;
         end
      endfunction

      function void check_field(input string name, input int unsigned want, got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_pick(input pick_type got);
         pick_type want;
         if (expected_picks.size() == 0) begin
            $error("result with no image pending: found=%0d color=%02h%02h%02h%02h",
                   got.found, got.red, got.green, got.blue, got.alpha);
            errors++;
            return;
         end
         want = expected_picks.pop_front();
         check_field("found", want.found, got.found);
         check_field("out_red", want.red, got.red);
         check_field("out_green", want.green, got.green);
         check_field("out_blue", want.blue, got.blue);
         check_field("out_alpha", want.alpha, got.alpha);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [dvcp_pkg::CsrIdxW-1:0]  csr_index;
   logic [dvcp_pkg::CsrDataW-1:0] csr_wdata;

   dvcp_req_if req_chan ();
   dvcp_rsp_if rsp_chan ();

   vibrant_pick_board board = new();

   int req_idle_pct;
   int rsp_stall_pct;
   bit rsp_hold_req;
   int quiet_cycles;

   dominant_vibrant_color_picker_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Result side: random stalls, plus a long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HoldOffCycles - 1) @(negedge clock);
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         board.note_pixel(req_chan.red, req_chan.green, req_chan.blue, req_chan.alpha,
                          req_chan.last);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         board.check_pick({rsp_chan.found, rsp_chan.out_red, rsp_chan.out_green,
                           rsp_chan.out_blue, rsp_chan.out_alpha});
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_pixel(input logic [7:0] red, green, blue, alpha, input logic last);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.red   <= red;
      req_chan.green <= green;
      req_chan.blue  <= blue;
      req_chan.alpha <= alpha;
      req_chan.last  <= last;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Holds the pixel stream until every owed result has come back.
   task automatic wait_results_done(input bit settle);
      req_chan.valid <= 1'b0;
      while (board.expected_picks.size() != 0) @(negedge clock);
      if (settle) repeat (SettleCycles) @(negedge clock);
   endtask

   task automatic csr_write(input logic [dvcp_pkg::CsrIdxW-1:0] index,
                            input logic [dvcp_pkg::CsrDataW-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   task automatic apply_settings(input logic [15:0] min_alpha, min_sat, min_value,
                                 max_value, sat_weight, value_weight);
      wait_results_done(1'b1);
      csr_write(dvcp_pkg::CsrMinAlpha, min_alpha);
      csr_write(dvcp_pkg::CsrMinSat, min_sat);
      csr_write(dvcp_pkg::CsrMinValue, min_value);
      csr_write(dvcp_pkg::CsrMaxValue, max_value);
      csr_write(dvcp_pkg::CsrSatWgt, sat_weight);
      csr_write(dvcp_pkg::CsrValWgt, value_weight);
      csr_wr_en <= 1'b0;
      board.settings.min_alpha    = min_alpha[7:0];
      board.settings.min_sat      = min_sat;
      board.settings.min_value    = min_value[7:0];
      board.settings.max_value    = max_value[7:0];
      board.settings.sat_weight   = sat_weight[8:0];
      board.settings.value_weight = value_weight[8:0];
   endtask

   task automatic apply_random_settings();
      logic [15:0] min_alpha, min_sat;
      min_alpha = ($urandom_range(0, 9) == 0) ? 16'd255 : 16'($urandom_range(0, 230));
      min_sat   = ($urandom_range(0, 9) == 0) ? 16'd65535 : 16'($urandom_range(0, 50000));
      apply_settings(min_alpha, min_sat, 16'($urandom_range(0, 130)),
                     16'($urandom_range(100, 255)), 16'($urandom_range(0, 511)),
                     16'($urandom_range(0, 511)));
   endtask

   function automatic pixel_type random_pixel(input pixel_type prev);
      pixel_type px;
      int        pick, near;
      pick = $urandom_range(0, 99);
      px.red   = 8'($urandom);
      px.green = 8'($urandom);
      px.blue  = 8'($urandom);
      if (pick < 10) begin
         px.green = px.red;
         px.blue  = px.red;
      end else if (pick < 20) begin
         px.red   = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         px.green = $urandom_range(0, 1) ? 8'd255 : 8'd0;
         px.blue  = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end else if (pick < 28) begin
         // Same color again, to land on equal scores.
         px.red   = prev.red;
         px.green = prev.green;
         px.blue  = prev.blue;
      end
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         px.alpha = 8'd255;
      end else if (pick < 75) begin
         px.alpha = 8'($urandom);
      end else begin
         near = int'(board.settings.min_alpha) + $urandom_range(0, 2) - 1;
         if (near < 0) near = 0;
         if (near > 255) near = 255;
         px.alpha = 8'(near);
      end
      return px;
   endfunction

   task automatic run_random_phase(input int idle_pct, stall_pct, item_goal, input bit hold_off);
      int        sent, images, len;
      bit        resettled;
      pixel_type px, prev;
      req_idle_pct  = idle_pct;
      rsp_stall_pct = stall_pct;
      sent      = 0;
      images    = 0;
      resettled = 1'b0;
      prev      = '0;
      apply_random_settings();
      while (sent < item_goal) begin
         if (!resettled && sent >= item_goal / 2) begin
            apply_random_settings();
            resettled = 1'b1;
         end
         if (hold_off && images == 20) rsp_hold_req = 1'b1;
         if (images == 60) wait_results_done(1'b0);
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            px = random_pixel(prev);
            send_pixel(px.red, px.green, px.blue, px.alpha, i == len - 1);
            prev = px;
            sent++;
         end
         images++;
      end
   endtask

   initial begin
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= '0;
      csr_wdata      <= '0;
      req_chan.valid <= 1'b0;
      req_chan.red   <= '0;
      req_chan.green <= '0;
      req_chan.blue  <= '0;
      req_chan.alpha <= '0;
      req_chan.last  <= 1'b0;
      rsp_chan.ready <= 1'b0;
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      rsp_hold_req  = 1'b0;
      quiet_cycles  = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings: value above the window, alpha skip, first vibrant pixel.
      send_pixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);
      send_pixel(8'd200, 8'd0, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
      // Equal scores keep the earlier pixel.
      send_pixel(8'd0, 8'd100, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd100, 8'd255, 1'b1);
      // Alpha one below and exactly at the threshold.
      send_pixel(8'd0, 8'd0, 8'd150, 8'd199, 1'b0);
      send_pixel(8'd150, 8'd0, 8'd0, 8'd200, 1'b1);
      // A later, higher score wins.
      send_pixel(8'd100, 8'd50, 8'd50, 8'd255, 1'b0);
      send_pixel(8'd200, 8'd10, 8'd10, 8'd255, 1'b1);
      // Gray and black pixels never qualify here.
      send_pixel(8'd128, 8'd128, 8'd128, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1);

      // Zero weights: every score is zero and the first qualifying pixel stays.
      apply_settings(16'd0, 16'd0, 16'd0, 16'd255, 16'd0, 16'd0);
      send_pixel(8'd10, 8'd10, 8'd10, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b1);

      // Empty value window: nothing qualifies.
      apply_settings(16'd255, 16'd65535, 16'd200, 16'd100, 16'd511, 16'd511);
      send_pixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b1);

      // Full saturation only, weights above one saturate.
      apply_settings(16'd255, 16'd65535, 16'd0, 16'd255, 16'd511, 16'd300);
      send_pixel(8'd255, 8'd0, 8'd0, 8'd255, 1'b0);
      send_pixel(8'd0, 8'd255, 8'd0, 8'd254, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 8'd255, 1'b1);
      send_pixel(8'd255, 8'd1, 8'd0, 8'd255, 1'b1);

      run_random_phase(0, 0, 340, 1'b1);
      run_random_phase(81, 0, 330, 1'b0);
      run_random_phase(0, 81, 330, 1'b0);
      run_random_phase(6, 6, 330, 1'b0);

      wait_results_done(1'b0);
      repeat (SettleCycles) @(posedge clock);
      if (board.errors == 0 && board.expected_picks.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
